### design/coalesced_hash_table_engine_assert.svh
// Assertion macros shared by the checker of the coalesced hash table engine.
// Each macro expands to one labeled concurrent assertion on the given clock and reset.
`ifndef COALESCED_HASH_TABLE_ENGINE_ASSERT_SVH
`define COALESCED_HASH_TABLE_ENGINE_ASSERT_SVH
// Implication checked at every edge outside reset.
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### design/chte_pkg.sv
// Package of the coalesced hash table engine: status codes, mode codes, queue entry type,
// back end state type and the key hash function. Depends on nothing.
`default_nettype none
package chte_pkg;
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] hash;
    } t_req;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_CHK, S_INS, S_FREE_RD, S_FREE_CHK,
        S_OCC_HASH, S_PRED_RD, S_PRED_CHK, S_MOVE, S_OUT
    } t_state;

    // SuperFastHash of the eight key bytes taken little-endian.
    function automatic logic [31:0] sfh_key(input logic [63:0] key);
        logic [31:0] h;
        logic [31:0] w;
        h = 32'd8;
        for (int i = 0; i < 2; i++) begin
            h = h + {16'd0, key[32*i +: 16]};
            w = {5'd0, key[32*i+16 +: 16], 11'd0} ^ h;
            h = {h[15:0], 16'd0} ^ w;
            h = h + (h >> 11);
        end
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction
endpackage
`default_nettype wire

### design/chte_front.sv
// Front end: takes request words, hashes the key and registers the result.
// Depends on chte_pkg.
`default_nettype none
module chte_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_mode,
    input  wire logic [63:0]   i_key,
    input  wire logic [63:0]   i_new_value,
    output logic               o_req_valid,
    input  wire logic          i_req_stall,
    output chte_pkg::t_req     o_req
);
    logic           r_valid;
    chte_pkg::t_req r_req;

    assign o_stall     = r_valid && i_req_stall;
    assign o_req_valid = r_valid;
    assign o_req       = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_req.mode  <= i_mode;
            r_req.key   <= i_key;
            r_req.value <= i_new_value;
            r_req.hash  <= chte_pkg::sfh_key(i_key);
        end
    end
endmodule
`default_nettype wire

### design/chte_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on chte_pkg.
`default_nettype none
module chte_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire chte_pkg::t_req i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output chte_pkg::t_req      o_data
);
    chte_pkg::t_req r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

### design/chte_back.sv
// Back end: owns the slot store, walks chains and carries out lookups and inserts.
// Depends on chte_pkg.
`default_nettype none
module chte_back #(
    parameter int TABLE_SIZE = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_stall,
    input  wire chte_pkg::t_req i_req,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [1:0]          o_status,
    output logic [7:0]          o_slot,
    output logic [63:0]         o_found_value
);
    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NULL_L = LW'(TABLE_SIZE);
    localparam logic [31:0] TS32 = 32'(TABLE_SIZE);

    // Slot store: key, value, link and used flag in one word per slot.
    logic [128+LW:0] r_mem [TABLE_SIZE];
    logic [128+LW:0] r_rd;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [128+LW:0] mem_wd;
    logic [AW-1:0]   mem_ra;

    chte_pkg::t_state r_st, n_st;
    chte_pkg::t_req   r_q, n_q;
    logic [LW-1:0]    r_idx, n_idx;
    logic [LW-1:0]    r_steps, n_steps;
    logic [LW-1:0]    r_free, n_free;
    logic [AW-1:0]    r_m, n_m;
    logic [AW-1:0]    r_f, n_f;
    logic [128+LW:0]  r_mword, n_mword;
    logic [31:0]      r_ohash, n_ohash;
    logic [1:0]       r_status, n_status;
    logic [7:0]       r_slot, n_slot;
    logic [63:0]      r_fval, n_fval;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_ostatus, n_ostatus;
    logic [7:0]       r_oslot, n_oslot;
    logic [63:0]      r_ofval, n_ofval;
    logic [AW-1:0]    r_ra, n_ra;

    logic            rd_used;
    logic [63:0]     rd_key;
    logic [63:0]     rd_val;
    logic [LW-1:0]   rd_link;
    logic [AW-1:0]   main_q;
    logic [AW-1:0]   main_o;

    assign rd_used = r_rd[128+LW];
    assign rd_key  = r_rd[127+LW -: 64];
    assign rd_val  = r_rd[63+LW -: 64];
    assign rd_link = r_rd[LW-1:0];
    assign main_q  = AW'(r_q.hash % TS32);
    assign main_o  = AW'(r_ohash % TS32);
    assign mem_ra  = r_ra;

    // The result word sits in its own registers, so the next request may start
    // while a stalled result waits.
    assign o_req_stall   = (r_st != chte_pkg::S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_slot        = r_oslot;
    assign o_found_value = r_ofval;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= chte_pkg::S_CLEAR;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_free   <= NULL_L;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
            r_free   <= n_free;
        end
        r_q       <= n_q;
        r_steps   <= n_steps;
        r_m       <= n_m;
        r_f       <= n_f;
        r_mword   <= n_mword;
        r_ohash   <= n_ohash;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_fval    <= n_fval;
        r_ostatus <= n_ostatus;
        r_oslot   <= n_oslot;
        r_ofval   <= n_ofval;
        r_ra      <= n_ra;
    end

    always_comb begin
        n_st      = r_st;
        n_q       = r_q;
        n_idx     = r_idx;
        n_steps   = r_steps;
        n_free    = r_free;
        n_m       = r_m;
        n_f       = r_f;
        n_mword   = r_mword;
        n_ohash   = r_ohash;
        n_status  = r_status;
        n_slot    = r_slot;
        n_fval    = r_fval;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_oslot   = r_oslot;
        n_ofval   = r_ofval;
        n_ra      = r_ra;
        mem_we    = 1'b0;
        mem_wa    = r_idx[AW-1:0];
        mem_wd    = '0;
        case (r_st)
            chte_pkg::S_CLEAR: begin
                // Clearing pass: mark every slot unused with a null link.
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                mem_wd = {1'b0, 128'd0, NULL_L};
                n_idx  = r_idx + 1'b1;
                if (r_idx == LW'(TABLE_SIZE - 1)) n_st = chte_pkg::S_IDLE;
            end
            chte_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_q      = i_req;
                    n_ra     = AW'(i_req.hash % TS32);
                    n_idx    = LW'(AW'(i_req.hash % TS32));
                    n_steps  = '0;
                    n_status = chte_pkg::ST_DONE;
                    n_slot   = '0;
                    n_fval   = '0;
                    n_st     = chte_pkg::S_RD;
                end
            end
            chte_pkg::S_RD: n_st = chte_pkg::S_CHK;
            chte_pkg::S_CHK: begin
                // Chain walk for the key; the data of slot r_idx is in r_rd.
                if (!rd_used) begin
                    n_st = chte_pkg::S_INS;
                end else if (rd_key == r_q.key) begin
                    n_slot = 8'(r_idx);
                    if (r_q.mode == chte_pkg::MODE_LOOKUP) begin
                        n_fval = rd_val;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = r_idx[AW-1:0];
                        mem_wd = {1'b1, rd_key, r_q.value, rd_link};
                    end
                    n_st = chte_pkg::S_OUT;
                end else if (rd_link >= NULL_L || r_steps == LW'(TABLE_SIZE - 1)) begin
                    n_st = chte_pkg::S_INS;
                end else begin
                    n_idx   = rd_link;
                    n_ra    = rd_link[AW-1:0];
                    n_steps = r_steps + 1'b1;
                    n_st    = chte_pkg::S_RD;
                end
            end
            chte_pkg::S_INS: begin
                if (r_q.mode == chte_pkg::MODE_LOOKUP) begin
                    n_status = chte_pkg::ST_MISS;
                    n_st     = chte_pkg::S_OUT;
                end else begin
                    n_m  = main_q;
                    n_ra = main_q;
                    n_st = chte_pkg::S_FREE_RD;
                    n_idx = NULL_L;
                end
            end
            chte_pkg::S_FREE_RD: begin
                // r_idx null marks the first pass: main slot read in flight.
                n_st = chte_pkg::S_FREE_CHK;
            end
            chte_pkg::S_FREE_CHK: begin
                if (r_idx == NULL_L) begin
                    if (!rd_used) begin
                        mem_we = 1'b1;
                        mem_wa = r_m;
                        mem_wd = {1'b1, r_q.key, r_q.value, NULL_L};
                        n_slot = 8'(r_m);
                        n_st   = chte_pkg::S_OUT;
                    end else begin
                        n_mword = r_rd;
                        n_ohash = chte_pkg::sfh_key(rd_key);
                        if (r_free == '0 || r_free > NULL_L) begin
                            n_free   = '0;
                            n_status = chte_pkg::ST_FULL;
                            n_st     = chte_pkg::S_OUT;
                        end else begin
                            n_free = r_free - 1'b1;
                            n_ra   = AW'(r_free - 1'b1);
                            n_idx  = '0;
                            n_st   = chte_pkg::S_FREE_RD;
                        end
                    end
                end else if (!rd_used) begin
                    n_f  = r_free[AW-1:0];
                    n_st = chte_pkg::S_OCC_HASH;
                end else if (r_free == '0) begin
                    n_status = chte_pkg::ST_FULL;
                    n_st     = chte_pkg::S_OUT;
                end else begin
                    n_free = r_free - 1'b1;
                    n_ra   = AW'(r_free - 1'b1);
                    n_st   = chte_pkg::S_FREE_RD;
                end
            end
            chte_pkg::S_OCC_HASH: begin
                if (main_o == r_m) begin
                    // Occupant is home: chain the new key right after it.
                    mem_we = 1'b1;
                    mem_wa = r_f;
                    mem_wd = {1'b1, r_q.key, r_q.value, r_mword[LW-1:0]};
                    n_mword = {r_mword[128+LW:LW], LW'(r_f)};
                    n_slot = 8'(r_f);
                    n_st   = chte_pkg::S_MOVE;
                    n_idx  = '0;
                end else begin
                    n_idx   = LW'(main_o);
                    n_ra    = main_o;
                    n_steps = '0;
                    n_st    = chte_pkg::S_PRED_RD;
                end
            end
            chte_pkg::S_PRED_RD: n_st = chte_pkg::S_PRED_CHK;
            chte_pkg::S_PRED_CHK: begin
                if (rd_link == LW'(r_m)) begin
                    mem_we = 1'b1;
                    mem_wa = r_idx[AW-1:0];
                    mem_wd = {r_rd[128+LW:LW], LW'(r_f)};
                    n_idx  = NULL_L;
                    n_st   = chte_pkg::S_MOVE;
                end else if (rd_link >= NULL_L || r_steps == LW'(TABLE_SIZE - 1)) begin
                    n_idx = NULL_L;
                    n_st  = chte_pkg::S_MOVE;
                end else begin
                    n_idx   = rd_link;
                    n_ra    = rd_link[AW-1:0];
                    n_steps = r_steps + 1'b1;
                    n_st    = chte_pkg::S_PRED_RD;
                end
            end
            chte_pkg::S_MOVE: begin
                // r_idx zero: update main slot link; else displace the occupant.
                if (r_idx == '0) begin
                    mem_we = 1'b1;
                    mem_wa = r_m;
                    mem_wd = r_mword;
                    n_st   = chte_pkg::S_OUT;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_f;
                    mem_wd = r_mword;
                    n_mword = {1'b1, r_q.key, r_q.value, NULL_L};
                    n_slot = 8'(r_m);
                    n_idx  = '0;
                end
            end
            chte_pkg::S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oslot   = r_slot;
                    n_ofval   = r_fval;
                    n_st      = chte_pkg::S_IDLE;
                end
            end
            default: n_st = chte_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### design/coalesced_hash_table_engine.sv
// Top level of the coalesced hash table engine: front end, queue and back end.
// Depends on chte_pkg, chte_front, chte_fifo and chte_back.
// An accepted word reaches the back end through the front register and the queue. The
// back end reads one slot at a time through its one read port, in a read state and a
// check state: a lookup or update that finds its key in the main slot passes through the
// read, check and output states, each further chain step adds a read and a check, a
// lookup miss adds the insert state, and an insert adds a read and a check per
// free-pointer step plus a read and a check per predecessor step when an occupant is
// moved. The back end works on one word at a time and takes its next word in the same
// cycle as it presents a result. After reset a clearing pass over every slot runs first.
`default_nettype none
module coalesced_hash_table_engine #(
    parameter int TABLE_SIZE = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_key,
    input  wire logic [63:0] i_new_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_slot,
    output logic [63:0]      o_found_value
);
    logic           f_valid, f_stall, b_valid, b_stall;
    chte_pkg::t_req f_req, b_req;

    chte_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_key, .i_new_value,
        .o_req_valid(f_valid), .i_req_stall(f_stall), .o_req(f_req)
    );
    chte_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_stall(f_stall), .i_data(f_req),
        .o_valid(b_valid), .i_stall(b_stall), .o_data(b_req)
    );
    chte_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(b_valid), .o_req_stall(b_stall), .i_req(b_req),
        .o_valid, .i_stall, .o_status, .o_slot, .o_found_value
    );
endmodule
`default_nettype wire

### design/chte_checker.sv
// Port checker of the coalesced hash table engine and its bind to the top level.
// Depends on chte_pkg and coalesced_hash_table_engine_assert.svh.
`default_nettype none
`include "coalesced_hash_table_engine_assert.svh"
module chte_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_slot,
    input wire logic [63:0] o_found_value
);
    logic is_done;
    logic is_legal;
    logic zero_payload;

    assign is_done      = (o_status == chte_pkg::ST_DONE);
    assign is_legal     = (o_status <= chte_pkg::ST_FULL);
    assign zero_payload = (o_slot == 8'd0) && (o_found_value == 64'd0);

    `CHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
    `CHT_ASSERT_IMP(a_status_legal, i_clk, i_rst_n, o_valid, is_legal)
    `CHT_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !is_done, zero_payload)
endmodule

bind coalesced_hash_table_engine chte_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_status, .o_slot, .o_found_value
);
`default_nettype wire

### verif/coalesced_hash_table_checker.sv
// Checker of the coalesced hash table engine: watches both channels, predicts each result
// with its own copy of the table and compares field by field. Depends on chte_pkg.
`default_nettype none
module coalesced_hash_table_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_key,
    input  wire logic [63:0] i_new_value,
    input  wire logic        i_valid_out,
    input  wire logic        i_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [7:0]  i_slot,
    input  wire logic [63:0] i_found_value,
    output int               o_errors,
    output int               o_pending
);
    localparam int SLOTS = 256;
    localparam logic [8:0] NO_LINK = 9'd256;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [63:0] value;
    } t_answer;

    t_answer     answers[$];
    logic        used[SLOTS];
    logic [63:0] keys[SLOTS];
    logic [63:0] vals[SLOTS];
    logic [8:0]  links[SLOTS];
    logic [8:0]  scan_ptr;

    function automatic logic [7:0] home_of(input logic [63:0] k);
        logic [31:0] h;
        logic [31:0] w;
        logic [31:0] lo;
        logic [31:0] hi;
        h = 32'd8;
        for (int n = 0; n < 2; n++) begin
            lo = {16'd0, k[32*n +: 16]};
            hi = {16'd0, k[32*n+16 +: 16]};
            h = h + lo;
            w = (hi << 11) ^ h;
            h = (h << 16) ^ w;
            h = h + (h >> 11);
        end
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h[7:0];
    endfunction

    function automatic logic [8:0] locate(input logic [63:0] k);
        logic [8:0] idx;
        idx = {1'b0, home_of(k)};
        for (int n = 0; n < SLOTS && idx < NO_LINK; n++) begin
            if (!used[idx]) return NO_LINK;
            if (keys[idx] == k) return idx;
            idx = links[idx];
        end
        return NO_LINK;
    endfunction

    function automatic logic [8:0] grab_free();
        while (scan_ptr > 0 && scan_ptr <= NO_LINK) begin
            scan_ptr = scan_ptr - 9'd1;
            if (!used[scan_ptr]) return scan_ptr;
        end
        scan_ptr = 9'd0;
        return NO_LINK;
    endfunction

    function automatic t_answer apply_word(input logic md, input logic [63:0] k,
                                           input logic [63:0] v);
        t_answer    r;
        logic [8:0] at;
        logic [8:0] m;
        logic [8:0] f;
        logic [8:0] om;
        logic [8:0] p;
        r = '0;
        at = locate(k);
        if (md == chte_pkg::MODE_LOOKUP) begin
            if (at < NO_LINK) begin
                r.slot = at[7:0];
                r.value = vals[at];
            end else begin
                r.status = chte_pkg::ST_MISS;
            end
        end else if (at < NO_LINK) begin
            vals[at] = v;
            r.slot = at[7:0];
        end else begin
            m = {1'b0, home_of(k)};
            if (!used[m]) begin
                used[m] = 1'b1;
                keys[m] = k;
                vals[m] = v;
                links[m] = NO_LINK;
                r.slot = m[7:0];
            end else begin
                f = grab_free();
                if (f >= NO_LINK) begin
                    r.status = chte_pkg::ST_FULL;
                end else begin
                    om = {1'b0, home_of(keys[m])};
                    if (om == m) begin
                        used[f] = 1'b1;
                        keys[f] = k;
                        vals[f] = v;
                        links[f] = links[m];
                        links[m] = f;
                        r.slot = f[7:0];
                    end else begin
                        // The squatter moves out; its predecessor must point at the new slot.
                        p = om;
                        for (int n = 0; n < SLOTS && p < NO_LINK; n++) begin
                            if (links[p] == m) begin
                                links[p] = f;
                                break;
                            end
                            p = links[p];
                        end
                        used[f] = 1'b1;
                        keys[f] = keys[m];
                        vals[f] = vals[m];
                        links[f] = links[m];
                        keys[m] = k;
                        vals[m] = v;
                        links[m] = NO_LINK;
                        r.slot = m[7:0];
                    end
                end
            end
        end
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
        scan_ptr = NO_LINK;
        for (int n = 0; n < SLOTS; n++) begin
            used[n] = 1'b0;
            keys[n] = '0;
            vals[n] = '0;
            links[n] = NO_LINK;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in)
                answers.push_back(apply_word(i_mode, i_key, i_new_value));
            if (i_valid_out && !i_stall) begin
                if (answers.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected word: status %0d slot %0d value %h",
                                 i_status, i_slot, i_found_value);
                end else begin
                    want = answers.pop_front();
                    if (want.status !== i_status || want.slot !== i_slot ||
                            want.value !== i_found_value) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected %0d/%0d/%h got %0d/%0d/%h",
                                     want.status, want.slot, want.value,
                                     i_status, i_slot, i_found_value);
                    end
                end
            end
        end
        o_pending = answers.size();
    end
endmodule
`default_nettype wire

### verif/tb_coalesced_hash_table_engine.sv
// Testbench top of coalesced_hash_table_engine: clock, reset, request stimulus, random
// stalls, the verdict. Depends on the engine, chte_pkg and coalesced_hash_table_checker.
`default_nettype none
module tb_coalesced_hash_table_engine;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = 1'b0;
    logic [63:0] i_key = '0;
    logic [63:0] i_new_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_slot;
    logic [63:0] o_found_value;
    int          errors;
    int          pending;
    logic        quiet = 1'b0;
    int          stall_left = 0;
    logic [63:0] stored[$];

    always #1 i_clk = ~i_clk;

    coalesced_hash_table_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_key(i_key), .i_new_value(i_new_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status), .o_slot(o_slot),
        .o_found_value(o_found_value)
    );

    coalesced_hash_table_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_mode(i_mode), .i_key(i_key), .i_new_value(i_new_value),
        .i_valid_out(o_valid), .i_stall(i_stall), .i_status(o_status), .i_slot(o_slot),
        .i_found_value(o_found_value), .o_errors(errors), .o_pending(pending)
    );

    // Receiver stalls come in bursts, and stop once the quiet stretch begins.
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Sends one word; with gaps allowed, a random burst of idle cycles may come first.
    task automatic send(input logic md, input logic [63:0] k, input logic [63:0] v);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= md;
        i_key <= k;
        i_new_value <= v;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        if (md == chte_pkg::MODE_INSERT) stored.push_back(k);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] ka;
        logic [63:0] kb;
        logic [63:0] kc;
        int          pick;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // On an empty table: A in its home, B collides and chains into the top slot,
        // then C whose home is that top slot forces B to move out.
        ka = rand64();
        if (chte_pkg::sfh_key(ka) % 256 == 255) ka = ka ^ 64'd1;
        do kb = rand64(); while (chte_pkg::sfh_key(kb) % 256 != chte_pkg::sfh_key(ka) % 256);
        do kc = rand64(); while (chte_pkg::sfh_key(kc) % 256 != 255);
        send(chte_pkg::MODE_LOOKUP, ka, rand64());
        send(chte_pkg::MODE_INSERT, ka, rand64());
        send(chte_pkg::MODE_INSERT, kb, rand64());
        send(chte_pkg::MODE_INSERT, kc, rand64());
        send(chte_pkg::MODE_LOOKUP, ka, '0);
        send(chte_pkg::MODE_LOOKUP, kb, '0);
        send(chte_pkg::MODE_LOOKUP, kc, '0);
        send(chte_pkg::MODE_INSERT, 64'd0, 64'd0);
        send(chte_pkg::MODE_INSERT, '1, '1);
        send(chte_pkg::MODE_LOOKUP, 64'd0, '1);
        send(chte_pkg::MODE_LOOKUP, '1, 64'd0);
        send(chte_pkg::MODE_INSERT, 64'd0, '1);
        send(chte_pkg::MODE_LOOKUP, 64'd0, 64'd0);
        send(chte_pkg::MODE_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send(chte_pkg::MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send(chte_pkg::MODE_LOOKUP, 64'h5555_5555_5555_5555, '0);
        send(chte_pkg::MODE_LOOKUP, 64'h8000_0000_0000_0001, '0);
        drain();

        // Mostly new inserts so the table fills up and later inserts are refused.
        for (int n = 0; n < 600; n++) begin
            if (n == 500) quiet = 1'b1;
            if (n == 300) drain();
            pick = $urandom_range(0, 9);
            if (pick < 6 || stored.size() == 0)
                send(chte_pkg::MODE_INSERT, rand64(), rand64());
            else if (pick < 8)
                send(chte_pkg::MODE_LOOKUP, stored[$urandom_range(0, stored.size() - 1)],
                     rand64());
            else if (pick < 9)
                send(chte_pkg::MODE_INSERT, stored[$urandom_range(0, stored.size() - 1)],
                     rand64());
            else
                send(chte_pkg::MODE_LOOKUP, rand64(), rand64());
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/chte_pkg.sv
design/chte_front.sv
design/chte_fifo.sv
design/chte_back.sv
design/coalesced_hash_table_engine.sv
design/chte_checker.sv
verif/coalesced_hash_table_checker.sv
verif/tb_coalesced_hash_table_engine.sv
